[rtl/binary_max_heap_queue_top_defines.svh]
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top_defines
// Assertion macros shared by the priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_TOP_DEFINES_SVH
`define BINARY_MAX_HEAP_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BHQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bhq_pkg.sv]
// ----------------------------------------------------------------------------
// bhq_pkg
// Types and constants for the max-priority queue and its cells.
// ----------------------------------------------------------------------------
package bhq_pkg;

    // port widths fixed by the interface
    localparam int KEY_IN_W  = 32;
    localparam int TOP_KEY_W = 32;
    localparam int COUNT_W   = 9;
    localparam int STATUS_W  = 2;

    // parameter defaults
    localparam int CAPACITY_DEF  = 256;
    localparam int KEY_WIDTH_DEF = 32;

    // operation codes
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_cmd;

endpackage

[rtl/bhq_cell.sv]
// ----------------------------------------------------------------------------
// bhq_cell
// One slot of the sorted key chain; keeps keys in descending order.
// ----------------------------------------------------------------------------
module bhq_cell #(
    parameter int KEY_WIDTH = bhq_pkg::KEY_WIDTH_DEF,
    parameter int CNT_W     = 9,
    parameter int IDX       = 0
) (
    input  logic                        i_clk,
    input  bhq_pkg::t_cell_cmd          i_cmd,
    input  logic signed [KEY_WIDTH-1:0] i_new_key,
    input  logic        [CNT_W-1:0]     i_count,
    input  logic                        i_prev_ge,
    input  logic signed [KEY_WIDTH-1:0] i_prev_key,
    input  logic signed [KEY_WIDTH-1:0] i_next_key,
    output logic                        o_ge,
    output logic signed [KEY_WIDTH-1:0] o_key,
    output logic signed [KEY_WIDTH-1:0] o_key_next
);
    import bhq_pkg::*;

    logic signed [KEY_WIDTH-1:0] r_key;
    logic signed [KEY_WIDTH-1:0] n_key;
    logic                        w_occupied;

    // slot holds a live key, and that key stays ahead of the new one
    assign w_occupied = CNT_W'(IDX) < i_count;
    assign o_ge       = w_occupied && (r_key >= i_new_key);

    // insert: keep, take new key, or take the key shifted from the neighbor
    // remove: take the key from the next slot
    always_comb begin
        n_key = r_key;
        if (i_cmd.push) begin
            if (!o_ge) begin
                n_key = i_prev_ge ? i_new_key : i_prev_key;
            end
        end else if (i_cmd.pop) begin
            n_key = i_next_key;
        end
    end

    // key storage
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key      = r_key;
    assign o_key_next = n_key;

endmodule

[rtl/binary_max_heap_queue_top.sv]
// ----------------------------------------------------------------------------
// binary_max_heap_queue_top
// Bounded max-priority queue of signed keys built from a chain of cells.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one operation per
// transaction: i_kind 0 pushes i_key, i_kind 1 pops the largest key.
// Output channel (o_out_valid / i_out_ready) returns one transaction per
// operation: the largest key now held (zero when empty), the nonempty flag,
// the entry count and a status (ok, push dropped when full, pop on empty).
// An accepted operation passes through the command register, then its result
// is registered in the output register.
// An operation is accepted only while the command register is empty; it is
// held there until it executes, then every cell of the chain updates at
// once from its own key, its neighbors' keys and the broadcast key.
// When the receiver stalls, the finished result waits in the output
// register; one further operation can be accepted and waits in the command
// register until the result is taken.
// Reset (synchronous, active low) empties the queue at once; key storage
// is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
`include "binary_max_heap_queue_top_defines.svh"

module binary_max_heap_queue_top #(
    parameter int CAPACITY  = bhq_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = bhq_pkg::KEY_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_kind,
    input  logic signed [bhq_pkg::KEY_IN_W-1:0]   i_key,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [bhq_pkg::TOP_KEY_W-1:0]  o_top_key,
    output logic                                  o_nonempty,
    output logic        [bhq_pkg::COUNT_W-1:0]    o_count,
    output logic        [bhq_pkg::STATUS_W-1:0]   o_status
);
    import bhq_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WIDE_W = 64;

    // command stage
    logic                        r_cmd_vld;
    logic                        r_cmd_kind;
    logic signed [KEY_WIDTH-1:0] r_cmd_key;
    logic signed [WIDE_W-1:0]    w_in_wide;
    logic                        w_in_fire;
    logic                        w_exec;

    // queue state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_full;
    logic             w_empty;
    t_status          w_status;
    t_cell_cmd        w_cell_cmd;

    // chain links
    logic signed [KEY_WIDTH-1:0] w_key  [CAPACITY];
    logic                        w_ge   [CAPACITY];
    logic signed [KEY_WIDTH-1:0] w_head_next;
    logic signed [WIDE_W-1:0]    w_top_wide;

    // result register
    logic                        r_out_vld;
    logic signed [TOP_KEY_W-1:0] r_out_top;
    logic                        r_out_nonempty;
    logic [COUNT_W-1:0]          r_out_count;
    t_status                     r_out_status;

    // input handshake and key sign extension from KEY_IN_W
    assign o_in_ready = !r_cmd_vld;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_in_wide  = WIDE_W'(i_key);
    assign w_exec     = r_cmd_vld && (!r_out_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
        end else if (w_in_fire) begin
            r_cmd_vld <= 1'b1;
        end else if (w_exec) begin
            r_cmd_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd_kind <= i_kind;
            r_cmd_key  <= w_in_wide[KEY_WIDTH-1:0];
        end
    end

    // operation decode and count update
    assign w_full  = r_count >= CNT_W'(CAPACITY);
    assign w_empty = r_count == '0;

    always_comb begin
        w_cell_cmd = '0;
        w_status   = ST_OK;
        n_count    = r_count;
        if (w_exec) begin
            if (r_cmd_kind == KIND_PUSH) begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_cell_cmd.push = 1'b1;
                    n_count         = r_count + 1'b1;
                end
            end else begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_cell_cmd.pop = 1'b1;
                    n_count        = r_count - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // chain of cells, head holds the maximum
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                        w_prev_ge;
        logic signed [KEY_WIDTH-1:0] w_prev_key;
        logic signed [KEY_WIDTH-1:0] w_next_key;
        logic signed [KEY_WIDTH-1:0] w_own_next;

        if (g == 0) begin : g_head
            assign w_prev_ge  = 1'b1;
            assign w_prev_key = w_key[g];
            assign w_head_next = w_own_next;
        end else begin : g_body
            assign w_prev_ge  = w_ge[g-1];
            assign w_prev_key = w_key[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next_key = w_key[g];
        end else begin : g_link
            assign w_next_key = w_key[g+1];
        end

        bhq_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CNT_W),
            .IDX       (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cell_cmd),
            .i_new_key  (r_cmd_key),
            .i_count    (r_count),
            .i_prev_ge  (w_prev_ge),
            .i_prev_key (w_prev_key),
            .i_next_key (w_next_key),
            .o_ge       (w_ge[g]),
            .o_key      (w_key[g]),
            .o_key_next (w_own_next)
        );
    end

    // result register
    assign w_top_wide = WIDE_W'(w_head_next);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_exec) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_out_top      <= (n_count == '0) ? '0 : w_top_wide[TOP_KEY_W-1:0];
            r_out_nonempty <= n_count != '0;
            r_out_count    <= COUNT_W'(n_count);
            r_out_status   <= w_status;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_top_key   = r_out_top;
    assign o_nonempty  = r_out_nonempty;
    assign o_count     = r_out_count;
    assign o_status    = r_out_status;

    // checks
    `BHQ_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(CAPACITY), "entry count above capacity")
    `BHQ_ASSERT_SAME(a_full_status, i_clk, i_rst_n,
        r_out_vld && (r_out_status == ST_FULL), r_count == CNT_W'(CAPACITY),
        "push dropped while queue not full")
    `BHQ_ASSERT_SAME(a_empty_status, i_clk, i_rst_n,
        r_out_vld && (r_out_status == ST_EMPTY), r_count == '0,
        "pop ignored while queue not empty")
    `BHQ_ASSERT_SAME(a_nonempty_match, i_clk, i_rst_n, r_out_vld,
        r_out_nonempty == (r_count != '0), "nonempty flag disagrees with count")
    `BHQ_ASSERT_NEXT(a_cmd_single, i_clk, i_rst_n, w_exec, !r_cmd_vld,
        "command register refilled in execute cycle")

endmodule

[dv/tb_binary_max_heap_queue_top.sv]
// ----------------------------------------------------------------------------
// tb_binary_max_heap_queue_top
// Self-checking testbench for the bounded max-priority queue.
// ----------------------------------------------------------------------------
// A shadow binary max-heap predicts every result from the operations that
// the queue accepts. Results are checked field by field in order of arrival.
// Stimulus runs through the empty and full corners, fill and drain passes
// with wide and extreme keys, random push/pop mixes with duplicate-heavy
// keys, a long receiver hold-off and back-to-back streaming with no idle
// cycles.
// ----------------------------------------------------------------------------
module tb_binary_max_heap_queue_top;
    import bhq_pkg::*;

    localparam int HEAP_DEPTH    = CAPACITY_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    // how the keys of a sequence are drawn
    typedef enum int {
        KEYS_WIDE,
        KEYS_NARROW,
        KEYS_EXTREME,
        KEYS_MIXED
    } t_key_mode;

    // one queue report as the block returns it
    typedef struct {
        logic signed [TOP_KEY_W-1:0] top_key;
        logic                        nonempty;
        logic [COUNT_W-1:0]          count;
        t_status                     status;
    } t_heap_report;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        i_kind      = KIND_PUSH;
    logic signed [KEY_IN_W-1:0]  i_key       = '0;
    logic                        i_out_ready = 1'b0;
    logic                        o_in_ready;
    logic                        o_out_valid;
    logic signed [TOP_KEY_W-1:0] o_top_key;
    logic                        o_nonempty;
    logic [COUNT_W-1:0]          o_count;
    logic [STATUS_W-1:0]         o_status;

    // shadow heap and the reports still owed by the queue
    logic signed [TOP_KEY_W-1:0] shadow_heap [HEAP_DEPTH];
    int                          shadow_count = 0;
    t_heap_report                owed_reports [$];
    t_heap_report                owed_head;

    int error_cnt   = 0;
    int report_cnt  = 0;
    int cycle_cnt   = 0;
    bit in_idle_en  = 1'b1;
    bit out_idle_en = 1'b1;
    int hold_seq    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;

    binary_max_heap_queue_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .i_key      (i_key),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_top_key  (o_top_key),
        .o_nonempty (o_nonempty),
        .o_count    (o_count),
        .o_status   (o_status)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("binary_max_heap_queue_top: mismatch");
            $finish;
        end
    end

    // apply one operation to the shadow heap and return the resulting report
    function automatic t_heap_report heap_apply(input logic kind,
                                                input logic signed [KEY_IN_W-1:0] key);
        t_heap_report                rep;
        int                          pos;
        int                          parent;
        int                          left;
        int                          right;
        int                          pick;
        bit                          settled;
        logic signed [TOP_KEY_W-1:0] tmp;
        rep.status = ST_OK;
        if (kind == KIND_PUSH) begin
            if (shadow_count >= HEAP_DEPTH) begin
                rep.status = ST_FULL;
            end else begin
                pos = shadow_count;
                shadow_heap[pos] = key;
                shadow_count++;
                settled = 1'b0;
                // sift up while the parent is strictly smaller
                while (pos > 0 && !settled) begin
                    parent = (pos - 1) / 2;
                    if (shadow_heap[parent] >= shadow_heap[pos]) begin
                        settled = 1'b1;
                    end else begin
                        tmp = shadow_heap[parent];
                        shadow_heap[parent] = shadow_heap[pos];
                        shadow_heap[pos] = tmp;
                        pos = parent;
                    end
                end
            end
        end else begin
            if (shadow_count == 0) begin
                rep.status = ST_EMPTY;
            end else begin
                shadow_count--;
                shadow_heap[0] = shadow_heap[shadow_count];
                pos = 0;
                settled = 1'b0;
                // sift down toward the larger child, left one on a tie
                while (!settled) begin
                    left  = 2 * pos + 1;
                    right = 2 * pos + 2;
                    if (left >= shadow_count) begin
                        settled = 1'b1;
                    end else begin
                        pick = left;
                        if (right < shadow_count && shadow_heap[left] < shadow_heap[right])
                            pick = right;
                        if (shadow_heap[pos] >= shadow_heap[pick]) begin
                            settled = 1'b1;
                        end else begin
                            tmp = shadow_heap[pos];
                            shadow_heap[pos] = shadow_heap[pick];
                            shadow_heap[pick] = tmp;
                            pos = pick;
                        end
                    end
                end
            end
        end
        rep.top_key  = (shadow_count > 0) ? shadow_heap[0] : '0;
        rep.nonempty = (shadow_count > 0);
        rep.count    = COUNT_W'(shadow_count);
        return rep;
    endfunction

    // receiver: stalls and hold-offs, checks each accepted report
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_reports.size() == 0) begin
                error_cnt++;
                if (report_cnt < MAX_REPORTS)
                    $display("unexpected report: top %0d nonempty %0b count %0d status %0d",
                             o_top_key, o_nonempty, o_count, o_status);
                report_cnt++;
            end else begin
                owed_head = owed_reports.pop_front();
                if (o_top_key !== owed_head.top_key || o_nonempty !== owed_head.nonempty ||
                    o_count !== owed_head.count || o_status !== owed_head.status) begin
                    error_cnt++;
                    if (report_cnt < MAX_REPORTS) begin
                        $display("report error: exp top %0d nonempty %0b count %0d status %0d",
                                 owed_head.top_key, owed_head.nonempty, owed_head.count,
                                 owed_head.status);
                        $display("              got top %0d nonempty %0b count %0d status %0d",
                                 o_top_key, o_nonempty, o_count, o_status);
                    end
                    report_cnt++;
                end
            end
        end
        if (hold_seq != hold_seen) begin
            hold_seen   <= hold_seq;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!out_idle_en) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 33);
        end
    end

    // offer one operation and wait for its transaction
    task automatic send_op(input logic kind, input logic signed [KEY_IN_W-1:0] key);
        bit gap;
        gap = in_idle_en && ($urandom_range(99) < 33);
        if (gap) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 33);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_key      <= key;
        do @(posedge i_clk); while (!o_in_ready);
        owed_reports = {owed_reports, heap_apply(kind, key)};
    endtask

    // stop offering and wait until every report is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (owed_reports.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [KEY_IN_W-1:0] pick_key(input t_key_mode mode);
        logic signed [KEY_IN_W-1:0] k;
        t_key_mode                  m;
        m = mode;
        if (m == KEYS_MIXED)
            m = t_key_mode'($urandom_range(2));
        case (m)
            KEYS_NARROW: begin
                k = $urandom_range(6);
                k = k - 3;
            end
            KEYS_EXTREME: begin
                case ($urandom_range(5))
                    0: k = 32'sh8000_0000;
                    1: k = 32'sh7fff_ffff;
                    2: k = 32'sh8000_0001;
                    3: k = 32'sh7fff_fffe;
                    4: k = '0;
                    default: k = '1;
                endcase
            end
            default: k = $urandom;
        endcase
        return k;
    endfunction

    // empty corner, extreme and equal keys
    task automatic test_directed_corners();
        int n;
        send_op(KIND_POP, '0);
        send_op(KIND_PUSH, 32'sh7fff_ffff);
        send_op(KIND_PUSH, 32'sh8000_0000);
        send_op(KIND_PUSH, '0);
        send_op(KIND_PUSH, '1);
        send_op(KIND_PUSH, 32'sh7fff_ffff);
        send_op(KIND_PUSH, 32'sd5);
        send_op(KIND_PUSH, 32'sd5);
        for (n = 0; n < 7; n++)
            send_op(KIND_POP, $urandom);
        send_op(KIND_POP, '1);
        send_op(KIND_PUSH, 32'sh8000_0000);
        send_op(KIND_POP, '0);
        wait_drained();
    endtask

    // fill past capacity, then drain past empty
    task automatic test_fill_and_drain(input t_key_mode mode);
        int n;
        for (n = 0; n < HEAP_DEPTH + 3; n++)
            send_op(KIND_PUSH, pick_key(mode));
        for (n = 0; n < HEAP_DEPTH + 3; n++)
            send_op(KIND_POP, $urandom);
        wait_drained();
    endtask

    // receiver holds off while operations keep coming, then paced bursts
    task automatic test_backpressure();
        int n;
        hold_seq <= hold_seq + 1;
        for (n = 0; n < 20; n++)
            send_op(($urandom_range(99) < 70) ? KIND_PUSH : KIND_POP, pick_key(KEYS_MIXED));
        wait_drained();
        for (n = 0; n < 10; n++)
            send_op(($urandom_range(99) < 50) ? KIND_PUSH : KIND_POP, pick_key(KEYS_WIDE));
        wait_drained();
        for (n = 0; n < 10; n++)
            send_op(($urandom_range(99) < 50) ? KIND_PUSH : KIND_POP, pick_key(KEYS_NARROW));
        wait_drained();
    endtask

    // random push/pop mix in chunks of varying push weight
    task automatic test_random_mix(input int chunks);
        int c;
        int n;
        int push_pct;
        for (c = 0; c < chunks; c++) begin
            case ($urandom_range(2))
                0: push_pct = 25;
                1: push_pct = 50;
                default: push_pct = 80;
            endcase
            for (n = 0; n < 50; n++)
                send_op(($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_POP,
                        pick_key(KEYS_MIXED));
        end
        wait_drained();
    endtask

    // back-to-back operations with no idle cycles on either side
    task automatic test_streaming();
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        test_random_mix(3);
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_corners();
        test_fill_and_drain(KEYS_WIDE);
        test_backpressure();
        test_random_mix(8);
        test_streaming();
        test_fill_and_drain(KEYS_EXTREME);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_cnt == 0 && owed_reports.size() == 0) begin
            $display("binary_max_heap_queue_top: match");
        end else begin
            $display("binary_max_heap_queue_top: mismatch");
        end
        $finish;
    end

endmodule
